// ----- rtl/gift_wrap_convex_hull_unit_macros.svh -----
// assertion macros for the checker file of the hull unit
`ifndef GIFT_WRAP_CONVEX_HULL_UNIT_MACROS_SVH
`define GIFT_WRAP_CONVEX_HULL_UNIT_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define GWCH_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define GWCH_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/gwch_pkg.sv -----
// types, widths and helpers shared by the gift-wrapping hull unit
package gwch_pkg;

  localparam int COORD_W = 16;
  localparam int HIDX_W  = 5;
  localparam int DIFF_W  = COORD_W + 1;
  localparam int PROD_W  = 2 * DIFF_W;

  typedef struct packed {
    logic signed [COORD_W-1:0] px;
    logic signed [COORD_W-1:0] py;
    logic                      last_point;
  } point_in_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] hull_x;
    logic signed [COORD_W-1:0] hull_y;
    logic [HIDX_W-1:0]         hull_index;
    logic                      hull_last;
    logic                      hull_error;
  } hull_out_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
  } pt_t;

  function automatic logic signed [DIFF_W-1:0] widen(input logic signed [COORD_W-1:0] v);
    widen = {v[COORD_W-1], v};
  endfunction

endpackage

// ----- rtl/gwch_ram.sv -----
// generic simple dual-port ram with registered read
module gwch_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/gift_wrap_convex_hull_unit.sv -----
// gift-wrapping convex hull unit: point store, start search and hull walk
//
// usage
//   in_valid/in_stall/in_data carry one point per beat; the beat with
//   last_point set closes the set and starts the walk. points beyond
//   MAX_POINTS are dropped, a last beat still starts the walk.
//   out_valid/out_stall/out_data carry the hull vertices in walk order,
//   the start vertex first and again at the end with hull_last set; a
//   walk that overruns the test budget or emission guard ends with one error beat.
// timing
//   a point beat is taken whenever in_valid is high and in_stall is low.
//   the walk first scans the stored points to find the start, then tests
//   candidates; every test reads all n stored points (n being the stored
//   point count) through the single read port of the point memory, one
//   point a cycle. in_stall stays high from the last beat until the
//   closing beat has been placed in the output register.
// reset and stall
//   rst_n clears the point count and the output valid flag; memory contents
//   are left as they are. a stalled output beat holds and the walk waits.
module gift_wrap_convex_hull_unit
  import gwch_pkg::*;
#(
  parameter int MAX_POINTS = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  point_in_t in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output hull_out_t out_data
);

  localparam int IW     = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CW     = $clog2(MAX_POINTS + 1);
  localparam int EW     = $clog2(MAX_POINTS + 2);
  localparam int BUDGET = (MAX_POINTS + 1) * (MAX_POINTS + 1);
  localparam int TW     = $clog2(BUDGET + 1);

  typedef enum logic [2:0] {
    S_LOAD,
    S_MIN,
    S_CAND,
    S_QRD,
    S_SCAN,
    S_DECIDE,
    S_EMIT
  } state_t;

  state_t                    state_r;
  logic [CW-1:0]             count_r;
  logic [CW-1:0]             scan_r;
  logic                      rd_vld_r;
  logic [IW-1:0]             rd_idx_r;
  logic signed [COORD_W-1:0] min_x_r, min_y_r;
  logic [IW-1:0]             start_r;
  logic [IW-1:0]             cur_r;
  logic [IW-1:0]             cand_r;
  logic [CW-1:0]             next_cand_r;
  logic signed [COORD_W-1:0] px_r, py_r, qx_r, qy_r;
  logic signed [DIFF_W-1:0]  ex_r, ey_r;
  logic [TW-1:0]             tests_r;
  logic [EW-1:0]             emitted_r;
  logic                      neg_r;
  logic signed [PROD_W-1:0]  pa_r, pb_r;
  logic                      p_vld_r;
  hull_out_t                 emit_r;
  logic                      emit_done_r;
  logic                      out_valid_r;
  hull_out_t                 out_data_r;

  logic                      ram_we;
  logic [IW-1:0]             ram_raddr;
  pt_t                       ram_wdata;
  pt_t                       ram_rdata;
  logic [CW-1:0]             cand_a, cand_b, cand_c;
  logic [IW-1:0]             cand_sel;
  logic signed [DIFF_W-1:0]  cx_d, cy_d;
  logic signed [PROD_W:0]    cross_d;
  hull_out_t                 err_beat;
  logic                      emit_load;

  gwch_ram #(
    .WIDTH ($bits(pt_t)),
    .DEPTH (MAX_POINTS)
  ) u_pts (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count_r[IW-1:0]),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign ram_we    = (state_r == S_LOAD) && in_valid && (count_r < CW'(MAX_POINTS));
  assign ram_wdata = '{x: in_data.px, y: in_data.py};
  assign ram_raddr = (state_r == S_CAND) ? cand_sel : scan_r[IW-1:0];

  // cyclic candidate choice, skipping the current vertex
  always_comb begin
    cand_a = (next_cand_r >= count_r) ? '0 : next_cand_r;
    cand_b = (cand_a == CW'(cur_r)) ? cand_a + CW'(1) : cand_a;
    cand_c = (cand_b >= count_r) ? '0 : cand_b;
    cand_sel = cand_c[IW-1:0];
  end

  assign cx_d    = widen(ram_rdata.x) - widen(px_r);
  assign cy_d    = widen(ram_rdata.y) - widen(py_r);
  assign cross_d = {pa_r[PROD_W-1], pa_r} - {pb_r[PROD_W-1], pb_r};

  assign err_beat = '{hull_x: '0, hull_y: '0, hull_index: '0, hull_last: 1'b1,
                      hull_error: 1'b1};

  // output register free or emptying this cycle
  assign emit_load = (state_r == S_EMIT) && (!out_valid_r || !out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      count_r     <= '0;
      scan_r      <= '0;
      rd_vld_r    <= 1'b0;
      p_vld_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (emit_load) begin
        out_valid_r <= 1'b1;
        out_data_r  <= emit_r;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_LOAD: begin
          if (in_valid) begin
            if (count_r < CW'(MAX_POINTS)) begin
              count_r <= count_r + CW'(1);
            end
            if (in_data.last_point) begin
              scan_r  <= '0;
              state_r <= S_MIN;
            end
          end
        end
        S_MIN: begin
          if (scan_r < count_r) begin
            scan_r   <= scan_r + CW'(1);
            rd_vld_r <= 1'b1;
            rd_idx_r <= scan_r[IW-1:0];
          end else begin
            rd_vld_r <= 1'b0;
          end
          if (rd_vld_r && (rd_idx_r == '0 || ram_rdata.x < min_x_r)) begin
            min_x_r <= ram_rdata.x;
            min_y_r <= ram_rdata.y;
            start_r <= rd_idx_r;
          end
          if (scan_r == count_r && !rd_vld_r) begin
            cur_r       <= start_r;
            px_r        <= min_x_r;
            py_r        <= min_y_r;
            next_cand_r <= '0;
            tests_r     <= '0;
            emitted_r   <= EW'(1);
            emit_r      <= '{hull_x: min_x_r, hull_y: min_y_r,
                             hull_index: HIDX_W'(start_r), hull_last: 1'b0,
                             hull_error: 1'b0};
            emit_done_r <= 1'b0;
            state_r     <= S_EMIT;
          end
        end
        S_CAND: begin
          if (tests_r >= TW'(BUDGET)) begin
            emit_r      <= err_beat;
            emit_done_r <= 1'b1;
            state_r     <= S_EMIT;
          end else begin
            tests_r <= tests_r + TW'(1);
            cand_r  <= cand_sel;
            state_r <= S_QRD;
          end
        end
        S_QRD: begin
          qx_r    <= ram_rdata.x;
          qy_r    <= ram_rdata.y;
          ex_r    <= cx_d;
          ey_r    <= cy_d;
          scan_r  <= '0;
          neg_r   <= 1'b0;
          state_r <= S_SCAN;
        end
        S_SCAN: begin
          if (scan_r < count_r) begin
            scan_r   <= scan_r + CW'(1);
            rd_vld_r <= 1'b1;
          end else begin
            rd_vld_r <= 1'b0;
          end
          if (rd_vld_r) begin
            pa_r    <= cx_d * ey_r;
            pb_r    <= cy_d * ex_r;
            p_vld_r <= 1'b1;
          end else begin
            p_vld_r <= 1'b0;
          end
          if (p_vld_r && cross_d[PROD_W]) begin
            neg_r <= 1'b1;
          end
          if (scan_r == count_r && !rd_vld_r && !p_vld_r) begin
            state_r <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          next_cand_r <= CW'(cand_r) + CW'(1);
          if (neg_r) begin
            state_r <= S_CAND;
          end else if (cand_r != start_r && emitted_r >= EW'(MAX_POINTS)) begin
            emit_r      <= err_beat;
            emit_done_r <= 1'b1;
            state_r     <= S_EMIT;
          end else begin
            cur_r       <= cand_r;
            px_r        <= qx_r;
            py_r        <= qy_r;
            emitted_r   <= emitted_r + EW'(1);
            emit_r      <= '{hull_x: qx_r, hull_y: qy_r,
                             hull_index: HIDX_W'(cand_r),
                             hull_last: (cand_r == start_r), hull_error: 1'b0};
            emit_done_r <= (cand_r == start_r);
            state_r     <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (emit_load) begin
            if (emit_done_r) begin
              count_r <= '0;
              state_r <= S_LOAD;
            end else begin
              state_r <= S_CAND;
            end
          end
        end
        default: begin
          state_r <= S_LOAD;
        end
      endcase
    end
  end

  assign in_stall  = (state_r != S_LOAD);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ----- rtl/gwch_checker.sv -----
// port-level checker for the hull unit and its bind
`include "gift_wrap_convex_hull_unit_macros.svh"

module gwch_checker
  import gwch_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input point_in_t in_data,
  input logic      out_valid,
  input logic      out_stall,
  input hull_out_t out_data
);

  `GWCH_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data), "result beat dropped or changed under stall")

  `GWCH_ASSERT_IMP(a_err_shape, out_valid && out_data.hull_error, out_data.hull_last && out_data.hull_index == '0 && out_data.hull_x == '0 && out_data.hull_y == '0, "error beat not closing or not cleared")

  `GWCH_ASSERT_IMP(a_walk_busy, out_valid && !out_data.hull_last, in_stall, "points taken while a walk is unfinished")

  `GWCH_ASSERT_NXT(a_walk_start, in_valid && !in_stall && in_data.last_point, in_stall, "walk did not start after the last point beat")

endmodule

bind gift_wrap_convex_hull_unit gwch_checker u_gwch_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

// ----- test/tb_gift_wrap_convex_hull_unit.sv -----
`timescale 1ns / 1ps
// self-checking testbench for the gift-wrapping convex hull unit
module tb_gift_wrap_convex_hull_unit;
  import gwch_pkg::*;

  localparam int MAX_POINTS     = 32;
  localparam int RANDOM_POINTS  = 200;
  localparam int WATCHDOG_LIMIT = 100000;
  localparam int HOLD_OFF_CYCLES = 3000;
  localparam int DRAIN_CYCLES   = 200;
  localparam int TEST_BUDGET    = (MAX_POINTS + 1) * (MAX_POINTS + 1);

  typedef enum int {SHAPE_SCATTER, SHAPE_CLUSTER, SHAPE_LINE, SHAPE_SAME} set_shape_t;

  typedef struct packed {
    point_in_t pt;
    logic      typed;
    hull_out_t vertex;
  } stim_row_t;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  point_in_t in_data;
  logic      out_valid;
  logic      out_stall;
  hull_out_t out_data;

  logic signed [COORD_W-1:0] store_x [MAX_POINTS];
  logic signed [COORD_W-1:0] store_y [MAX_POINTS];
  int unsigned stored_count;
  hull_out_t   walk_beats[$];
  hull_out_t   expected_vertices[$];
  stim_row_t   directed_rows[$];
  int          failures;
  int          quiet_cycles;
  bit          hold_off_armed;

  gift_wrap_convex_hull_unit #(.MAX_POINTS(MAX_POINTS)) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic void add_walk_beat(input hull_out_t b);
    walk_beats.insert(walk_beats.size(), b);
  endfunction

  function automatic void add_expected(input hull_out_t b);
    expected_vertices.insert(expected_vertices.size(), b);
  endfunction

  function automatic void add_row(input stim_row_t r);
    directed_rows.insert(directed_rows.size(), r);
  endfunction

  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic hull_out_t hull_beat(input logic signed [COORD_W-1:0] x,
                                          input logic signed [COORD_W-1:0] y,
                                          input logic [HIDX_W-1:0] index,
                                          input logic last, input logic err);
    hull_out_t b;
    b.hull_x     = x;
    b.hull_y     = y;
    b.hull_index = index;
    b.hull_last  = last;
    b.hull_error = err;
    return b;
  endfunction

  // no stored point strictly on the negative side of from -> to
  function automatic bit side_clear(input int unsigned from_i, input int unsigned to_i);
    longint ax, ay, ex, ey, cx, cy;
    int unsigned i;
    ax = store_x[from_i];
    ay = store_y[from_i];
    ex = store_x[to_i] - ax;
    ey = store_y[to_i] - ay;
    for (i = 0; i < stored_count; i++) begin
      cx = store_x[i] - ax;
      cy = store_y[i] - ay;
      if (cx * ey - cy * ex < 0) return 1'b0;
    end
    return 1'b1;
  endfunction

  task automatic hull_predict(input point_in_t pt);
    int unsigned start, cur, cand, next_cand, tests, emitted, i;
    bit closing;
    walk_beats.delete();
    if (stored_count < MAX_POINTS) begin
      store_x[stored_count] = pt.px;
      store_y[stored_count] = pt.py;
      stored_count++;
    end
    if (!pt.last_point) return;
    start = 0;
    for (i = 1; i < stored_count; i++)
      if (store_x[i] < store_x[start]) start = i;
    cur       = start;
    next_cand = 0;
    tests     = 0;
    add_walk_beat(hull_beat(store_x[start], store_y[start], HIDX_W'(start), 1'b0, 1'b0));
    emitted = 1;
    forever begin
      cand = next_cand;
      if (cand >= stored_count) cand = 0;
      if (cand == cur) cand++;
      if (cand >= stored_count) cand = 0;
      if (tests >= TEST_BUDGET) begin
        add_walk_beat(hull_beat('0, '0, '0, 1'b1, 1'b1));
        break;
      end
      tests++;
      if (side_clear(cur, cand)) begin
        closing = (cand == start);
        if (!closing && emitted >= MAX_POINTS) begin
          add_walk_beat(hull_beat('0, '0, '0, 1'b1, 1'b1));
          break;
        end
        cur = cand;
        add_walk_beat(hull_beat(store_x[cand], store_y[cand], HIDX_W'(cand), closing,
                                1'b0));
        emitted++;
        if (closing) break;
      end
      next_cand = cand + 1;
    end
    stored_count = 0;
  endtask

  task automatic load_point(input point_in_t pt, input bit steady, input bit typed,
                            input hull_out_t typed_vertex);
    int unsigned gap;
    hull_out_t closing_vertex;
    gap = steady ? 0 : gap_len();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= pt;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    hull_predict(pt);
    if (typed) begin
      closing_vertex = typed_vertex;
      closing_vertex.hull_last = 1'b1;
      add_expected(typed_vertex);
      add_expected(closing_vertex);
    end else begin
      foreach (walk_beats[k]) add_expected(walk_beats[k]);
    end
  endtask

  function automatic stim_row_t plot(input int x, input int y, input bit last,
                                     input bit typed, input int ex, input int ey,
                                     input int eidx);
    stim_row_t r;
    r.pt.px         = COORD_W'(x);
    r.pt.py         = COORD_W'(y);
    r.pt.last_point = last;
    r.typed         = typed;
    r.vertex        = hull_beat(COORD_W'(ex), COORD_W'(ey), HIDX_W'(eidx), 1'b0, 1'b0);
    return r;
  endfunction

  // stall pattern of the result side
  initial begin : result_sink
    int unsigned stall_left, span;
    bit steady;
    out_stall  = 1'b0;
    stall_left = 0;
    span       = 0;
    steady     = 1'b0;
    forever begin
      @(posedge clk);
      if (span == 0) begin
        span   = $urandom_range(50, 400);
        steady = ($urandom_range(0, 3) == 0);
      end
      span--;
      if (hold_off_armed && out_valid === 1'b1) begin
        hold_off_armed = 1'b0;
        stall_left     = HOLD_OFF_CYCLES;
      end else if (stall_left == 0 && !steady && $urandom_range(0, 2) == 0) begin
        stall_left = gap_len();
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : vertex_check
    hull_out_t want;
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (expected_vertices.size() == 0) begin
        $error("hull beat with nothing expected: x %0d y %0d index %0d",
               out_data.hull_x, out_data.hull_y, out_data.hull_index);
        failures++;
      end else begin
        want = expected_vertices.pop_front();
        if (out_data.hull_x !== want.hull_x) begin
          $error("hull_x: expected %0d, got %0d", want.hull_x, out_data.hull_x);
          failures++;
        end
        if (out_data.hull_y !== want.hull_y) begin
          $error("hull_y: expected %0d, got %0d", want.hull_y, out_data.hull_y);
          failures++;
        end
        if (out_data.hull_index !== want.hull_index) begin
          $error("hull_index: expected %0d, got %0d", want.hull_index, out_data.hull_index);
          failures++;
        end
        if (out_data.hull_last !== want.hull_last) begin
          $error("hull_last: expected %0d, got %0d", want.hull_last, out_data.hull_last);
          failures++;
        end
        if (out_data.hull_error !== want.hull_error) begin
          $error("hull_error: expected %0d, got %0d", want.hull_error, out_data.hull_error);
          failures++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n !== 1'b1 || (in_valid && in_stall === 1'b0) ||
        (out_valid === 1'b1 && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $error("no beat accepted for %0d cycles", WATCHDOG_LIMIT);
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    point_in_t   pt;
    set_shape_t  shape;
    int unsigned points_sent, size, pick, k;
    int          anchor_x, anchor_y, dx, dy, step;
    bit          first, steady;

    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_data        = '0;
    failures       = 0;
    quiet_cycles   = 0;
    stored_count   = 0;
    hold_off_armed = 1'b0;

    // px, py, last, typed, expected x, y, index
    add_row(plot(-32768, -32768, 1, 1, -32768, -32768, 0));
    add_row(plot( 32767,  32767, 1, 1,  32767,  32767, 0));
    add_row(plot(    -1,      0, 1, 1,     -1,      0, 0));
    // two points
    add_row(plot( 32767, -32768, 0, 0, 0, 0, 0));
    add_row(plot(-32768,  32767, 1, 0, 0, 0, 0));
    // square with interior and edge points
    add_row(plot( 32767,  32767, 0, 0, 0, 0, 0));
    add_row(plot(-32768,  32767, 0, 0, 0, 0, 0));
    add_row(plot(     0,      0, 0, 0, 0, 0, 0));
    add_row(plot(-32768, -32768, 0, 0, 0, 0, 0));
    add_row(plot( 32767, -32768, 0, 0, 0, 0, 0));
    add_row(plot(     0, -32768, 1, 0, 0, 0, 0));
    // tie on least x
    add_row(plot(-5,  4, 0, 0, 0, 0, 0));
    add_row(plot(-5, -4, 0, 0, 0, 0, 0));
    add_row(plot( 3,  0, 0, 0, 0, 0, 0));
    add_row(plot(-5,  0, 1, 0, 0, 0, 0));
    // duplicates
    add_row(plot(7, 7, 0, 0, 0, 0, 0));
    add_row(plot(7, 7, 0, 0, 0, 0, 0));
    add_row(plot(7, 7, 1, 0, 0, 0, 0));
    // collinear
    add_row(plot( 4,  4, 0, 0, 0, 0, 0));
    add_row(plot(-2, -2, 0, 0, 0, 0, 0));
    add_row(plot( 1,  1, 0, 0, 0, 0, 0));
    add_row(plot(10, 10, 1, 0, 0, 0, 0));

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[r])
      load_point(directed_rows[r].pt, 1'($urandom_range(0, 1)), directed_rows[r].typed,
                 directed_rows[r].vertex);

    hold_off_armed = 1'b1;
    points_sent    = 0;
    first          = 1'b1;
    while (points_sent < RANDOM_POINTS) begin
      pick = $urandom_range(0, 99);
      if (first) begin
        size  = MAX_POINTS;
        shape = SHAPE_SAME;
        first = 1'b0;
      end else begin
        size = pick < 70 ? $urandom_range(1, 8) :
               pick < 85 ? $urandom_range(9, 20) :
               pick < 95 ? $urandom_range(21, MAX_POINTS) :
                           $urandom_range(MAX_POINTS + 1, MAX_POINTS + 4);
        pick  = $urandom_range(0, 99);
        shape = pick < 50 ? SHAPE_SCATTER : pick < 75 ? SHAPE_CLUSTER :
                pick < 90 ? SHAPE_LINE : SHAPE_SAME;
      end
      if (shape == SHAPE_LINE) begin
        anchor_x = $urandom_range(0, 2000);
        anchor_y = $urandom_range(0, 2000);
        anchor_x = anchor_x - 1000;
        anchor_y = anchor_y - 1000;
      end else begin
        anchor_x = $urandom_range(0, 65535);
        anchor_y = $urandom_range(0, 65535);
        anchor_x = anchor_x - 32768;
        anchor_y = anchor_y - 32768;
      end
      dx = $urandom_range(0, 6);
      dy = $urandom_range(0, 6);
      dx = dx - 3;
      dy = dy - 3;
      steady = ($urandom_range(0, 4) == 0);
      for (k = 0; k < size; k++) begin
        case (shape)
          SHAPE_SCATTER: begin
            pt.px = COORD_W'($urandom);
            pt.py = COORD_W'($urandom);
          end
          SHAPE_CLUSTER: begin
            pt.px = COORD_W'($urandom_range(0, 6) - 3);
            pt.py = COORD_W'($urandom_range(0, 6) - 3);
          end
          SHAPE_LINE: begin
            step  = $urandom_range(0, 20);
            pt.px = COORD_W'(anchor_x + step * dx);
            pt.py = COORD_W'(anchor_y + step * dy);
          end
          default: begin
            pt.px = COORD_W'(anchor_x);
            pt.py = COORD_W'(anchor_y);
          end
        endcase
        pt.last_point = (k == size - 1);
        load_point(pt, steady, 1'b0, '0);
        points_sent++;
      end
    end
    in_valid <= 1'b0;

    while (expected_vertices.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (failures == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
